[sv/rbl_pkg.sv]
package rbl_pkg;

  // Input item
  typedef struct packed {
    logic [2:0] opcode;
    logic       rx_pin;
    logic [1:0] argument;
  } rbl_in_t;

  // Result item
  typedef struct packed {
    logic        ack;
    logic        rx_bit_valid;
    logic        rx_bit;
    logic        tx_bit_request;
    logic        ctl0;
    logic        ctl1;
    logic        txd;
    logic [15:0] compare_value;
    logic        load_compare;
    logic        clear_counter;
    logic        timer_enable;
    logic [2:0]  radio_mode;
  } rbl_out_t;

  // Configuration register file contents
  typedef struct packed {
    logic [15:0] off_period;
    logic [15:0] on_period;
    logic [15:0] full_bit_period;
    logic [15:0] rate_one_period;
    logic [15:0] rate_two_period;
    logic [2:0]  silence_limit;
  } rbl_cfg_t;

  // Opcodes
  localparam logic [2:0] OP_TICK     = 3'd0;
  localparam logic [2:0] OP_SEND_BIT = 3'd1;
  localparam logic [2:0] OP_POWER    = 3'd2;
  localparam logic [2:0] OP_TX_MODE  = 3'd3;
  localparam logic [2:0] OP_RX_MODE  = 3'd4;
  localparam logic [2:0] OP_SET_RATE = 3'd5;

  // Power command arguments
  localparam logic [1:0] PWR_OFF = 2'd0;
  localparam logic [1:0] PWR_ON  = 2'd1;

  // Rate levels
  localparam logic [1:0] RATE_ON   = 2'd0;
  localparam logic [1:0] RATE_ONE  = 2'd1;
  localparam logic [1:0] RATE_TWO  = 2'd2;
  localparam logic [1:0] RATE_FULL = 2'd3;

  // Reported radio mode codes
  localparam logic [2:0] RM_RX        = 3'd0;
  localparam logic [2:0] RM_TX        = 3'd1;
  localparam logic [2:0] RM_OFF       = 3'd2;
  localparam logic [2:0] RM_SENSE_OFF = 3'd3;
  localparam logic [2:0] RM_SENSE_ON  = 3'd4;

  // Configuration register indexes
  localparam logic [2:0] CFG_OFF_PERIOD      = 3'd0;
  localparam logic [2:0] CFG_ON_PERIOD       = 3'd1;
  localparam logic [2:0] CFG_FULL_BIT_PERIOD = 3'd2;
  localparam logic [2:0] CFG_RATE_ONE_PERIOD = 3'd3;
  localparam logic [2:0] CFG_RATE_TWO_PERIOD = 3'd4;
  localparam logic [2:0] CFG_SILENCE_LIMIT   = 3'd5;

  // Reset values
  localparam logic [15:0] RST_OFF_PERIOD      = 16'd1040;
  localparam logic [15:0] RST_ON_PERIOD       = 16'd80;
  localparam logic [15:0] RST_FULL_BIT_PERIOD = 16'd200;
  localparam logic [15:0] RST_RATE_ONE_PERIOD = 16'd300;
  localparam logic [15:0] RST_RATE_TWO_PERIOD = 16'd400;
  localparam logic [2:0]  RST_SILENCE_LIMIT   = 3'd6;

  // Zero-run counter saturation point
  localparam logic [2:0] ZERO_RUN_MAX = 3'd7;

endpackage

[sv/rbl_cfg.sv]
module rbl_cfg (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic [2:0]          cfg_index,
  input  logic [15:0]         cfg_wdata,
  output rbl_pkg::rbl_cfg_t   cfg
);
  import rbl_pkg::*;

  rbl_cfg_t cfg_r;

  // Register file; writes beyond the list are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.off_period      <= RST_OFF_PERIOD;
      cfg_r.on_period       <= RST_ON_PERIOD;
      cfg_r.full_bit_period <= RST_FULL_BIT_PERIOD;
      cfg_r.rate_one_period <= RST_RATE_ONE_PERIOD;
      cfg_r.rate_two_period <= RST_RATE_TWO_PERIOD;
      cfg_r.silence_limit   <= RST_SILENCE_LIMIT;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_OFF_PERIOD:      cfg_r.off_period      <= cfg_wdata;
        CFG_ON_PERIOD:       cfg_r.on_period       <= cfg_wdata;
        CFG_FULL_BIT_PERIOD: cfg_r.full_bit_period <= cfg_wdata;
        CFG_RATE_ONE_PERIOD: cfg_r.rate_one_period <= cfg_wdata;
        CFG_RATE_TWO_PERIOD: cfg_r.rate_two_period <= cfg_wdata;
        CFG_SILENCE_LIMIT:   cfg_r.silence_limit   <= cfg_wdata[2:0];
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

[sv/rbl_core.sv]
module rbl_core (
  input  logic               clk,
  input  logic               rst_n,
  input  rbl_pkg::rbl_cfg_t  cfg,
  input  logic               fire,
  input  rbl_pkg::rbl_in_t   item,
  output rbl_pkg::rbl_out_t  res
);
  import rbl_pkg::*;

  typedef enum logic [4:0] {
    ST_RX        = 5'b00001,
    ST_TX        = 5'b00010,
    ST_OFF       = 5'b00100,
    ST_SENSE_OFF = 5'b01000,
    ST_SENSE_ON  = 5'b10000
  } mode_t;

  mode_t       mode_r, mode_nxt;
  logic [2:0]  zero_run_r, zero_run_nxt;
  logic        ctl0_r, ctl0_nxt;
  logic        ctl1_r, ctl1_nxt;
  logic        txd_r, txd_nxt;
  logic        timer_on_r, timer_on_nxt;
  logic [15:0] period_r, period_nxt;

  logic        do_rate;
  logic [1:0]  rate_lvl;
  logic        load, clear;
  logic        ack, rv, rb, treq;
  logic [2:0]  mode_code;

  // Next-state and result decode for one item
  always_comb begin
    mode_nxt     = mode_r;
    zero_run_nxt = zero_run_r;
    ctl0_nxt     = ctl0_r;
    ctl1_nxt     = ctl1_r;
    txd_nxt      = txd_r;
    timer_on_nxt = timer_on_r;
    period_nxt   = period_r;
    do_rate      = 1'b0;
    rate_lvl     = RATE_FULL;
    load         = 1'b0;
    clear        = 1'b0;
    ack          = 1'b0;
    rv           = 1'b0;
    rb           = 1'b0;
    treq         = 1'b0;

    case (item.opcode)
      OP_TICK: begin
        if (timer_on_r) begin
          case (mode_r)
            ST_TX: treq = 1'b1;
            ST_RX: begin
              if (item.rx_pin) begin
                zero_run_nxt = '0;
              end else if (zero_run_r != ZERO_RUN_MAX) begin
                zero_run_nxt = 3'(zero_run_r + 3'd1);
              end
              rv = 1'b1;
              rb = item.rx_pin;
              if (zero_run_nxt > cfg.silence_limit) mode_nxt = ST_SENSE_OFF;
            end
            ST_SENSE_OFF: begin
              mode_nxt   = ST_SENSE_ON;
              period_nxt = cfg.on_period;
              load       = 1'b1;
              ctl0_nxt   = 1'b1;
              ctl1_nxt   = 1'b1;
            end
            ST_SENSE_ON: begin
              rv = 1'b1;
              rb = item.rx_pin;
              if (item.rx_pin) begin
                // carrier heard: back to receive at full bit period
                do_rate      = 1'b1;
                rate_lvl     = RATE_FULL;
                mode_nxt     = ST_RX;
                zero_run_nxt = '0;
              end else begin
                mode_nxt   = ST_SENSE_OFF;
                period_nxt = cfg.off_period;
                load       = 1'b1;
                ctl0_nxt   = 1'b0;
                ctl1_nxt   = 1'b0;
              end
            end
            default: ;
          endcase
        end
      end
      OP_SEND_BIT: begin
        if (mode_r == ST_TX) begin
          txd_nxt = item.argument[0];
          ack     = 1'b1;
        end
      end
      OP_POWER: begin
        if (item.argument == PWR_OFF) begin
          ctl0_nxt     = 1'b0;
          ctl1_nxt     = 1'b0;
          timer_on_nxt = 1'b0;
          mode_nxt     = ST_OFF;
        end else if (item.argument == PWR_ON) begin
          mode_nxt     = ST_SENSE_OFF;
          timer_on_nxt = 1'b1;
        end
        ack = 1'b1;
      end
      OP_TX_MODE: begin
        ctl0_nxt = 1'b1;
        ctl1_nxt = 1'b0;
        mode_nxt = ST_TX;
        ack      = 1'b1;
      end
      OP_RX_MODE: begin
        ctl0_nxt = 1'b1;
        ctl1_nxt = 1'b1;
        txd_nxt  = 1'b0;
        do_rate  = 1'b1;
        rate_lvl = RATE_FULL;
        mode_nxt = ST_SENSE_ON;
        ack      = 1'b1;
      end
      OP_SET_RATE: begin
        do_rate  = 1'b1;
        rate_lvl = item.argument;
        ack      = 1'b1;
      end
      default: ;
    endcase

    // Rate level load; levels 1 and 2 keep the counter running
    if (do_rate) begin
      load = 1'b1;
      case (rate_lvl)
        RATE_ON: begin
          period_nxt = cfg.on_period;
          clear      = 1'b1;
        end
        RATE_ONE: period_nxt = cfg.rate_one_period;
        RATE_TWO: period_nxt = cfg.rate_two_period;
        default: begin
          period_nxt = cfg.full_bit_period;
          clear      = 1'b1;
        end
      endcase
    end
  end

  // Reported mode code
  always_comb begin
    case (mode_nxt)
      ST_RX:        mode_code = RM_RX;
      ST_TX:        mode_code = RM_TX;
      ST_OFF:       mode_code = RM_OFF;
      ST_SENSE_OFF: mode_code = RM_SENSE_OFF;
      ST_SENSE_ON:  mode_code = RM_SENSE_ON;
      default:      mode_code = RM_RX;
    endcase
  end

  assign res.ack            = ack;
  assign res.rx_bit_valid   = rv;
  assign res.rx_bit         = rb;
  assign res.tx_bit_request = treq;
  assign res.ctl0           = ctl0_nxt;
  assign res.ctl1           = ctl1_nxt;
  assign res.txd            = txd_nxt;
  assign res.compare_value  = period_nxt;
  assign res.load_compare   = load;
  assign res.clear_counter  = clear;
  assign res.timer_enable   = timer_on_nxt;
  assign res.radio_mode     = mode_code;

  // Controller state, advanced once per transfer to the result stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r     <= ST_RX;
      zero_run_r <= '0;
      ctl0_r     <= 1'b1;
      ctl1_r     <= 1'b1;
      txd_r      <= 1'b0;
      timer_on_r <= 1'b1;
      period_r   <= RST_FULL_BIT_PERIOD;
    end else if (fire) begin
      mode_r     <= mode_nxt;
      zero_run_r <= zero_run_nxt;
      ctl0_r     <= ctl0_nxt;
      ctl1_r     <= ctl1_nxt;
      txd_r      <= txd_nxt;
      timer_on_r <= timer_on_nxt;
      period_r   <= period_nxt;
    end
  end

`ifndef SYNTHESIS
  // Off mode is only reached with the timer stopped
  a_off_timer_stopped: assert property (@(posedge clk) disable iff (!rst_n)
    mode_r == ST_OFF |-> !timer_on_r)
    else $error("off mode with timer running");

  // Counter clear only comes with a period load
  a_clear_needs_load: assert property (@(posedge clk) disable iff (!rst_n)
    res.clear_counter |-> res.load_compare)
    else $error("counter clear without compare load");

  // Receive command lands in sense-on at the full bit period
  a_rx_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    fire && item.opcode == OP_RX_MODE |=>
      mode_r == ST_SENSE_ON && period_r == $past(cfg.full_bit_period))
    else $error("receive command did not enter sense-on");

  // A tick with the timer stopped leaves the state alone
  a_tick_stopped: assert property (@(posedge clk) disable iff (!rst_n)
    fire && item.opcode == OP_TICK && !timer_on_r |=>
      $stable(mode_r) && $stable(zero_run_r) && $stable(period_r))
    else $error("tick changed state with timer stopped");
`endif

endmodule

[sv/radio_bit_low_power_listen.sv]
// Channel | Ports                                  | Direction
// input   | in_valid, in_ready, in_data            | item in
// result  | out_valid, out_ready, out_data         | item out
// config  | cfg_we, cfg_index, cfg_wdata           | write only
//
// One item per cycle sustained while out_ready stays high; a result passes
// through the input register, then the result register.
// Both stages hold under stall; in_ready stays high while the input stage
// is empty or can drain into the result stage in the same cycle.
// Synchronous active-low reset clears valid flags, controller state and
// configuration registers to their defaults.
module radio_bit_low_power_listen (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  rbl_pkg::rbl_in_t   in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output rbl_pkg::rbl_out_t  out_data,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [15:0]        cfg_wdata
);
  import rbl_pkg::*;

  rbl_cfg_t cfg;
  rbl_in_t  in_data_r;
  logic     in_valid_r;
  rbl_out_t out_data_r;
  logic     out_valid_r;
  rbl_out_t res;
  logic     move;

  rbl_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  // Input stage drains when the result stage is empty or being taken
  assign move     = in_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !in_valid_r || move;

  rbl_core u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .cfg   (cfg),
    .fire  (move),
    .item  (in_data_r),
    .res   (res)
  );

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ready) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_data_r <= in_data;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (move) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (move) begin
      out_data_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

[tb/radio_bit_low_power_listen_tb.sv]
module radio_bit_low_power_listen_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import rbl_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int SHOWN_MISMATCHES = 10;

  // opcodes with no command behind them
  localparam logic [2:0] OP_SPARE_SIX   = 3'd6;
  localparam logic [2:0] OP_SPARE_SEVEN = 3'd7;

  typedef enum int {SCN_LISTEN, SCN_TX, SCN_CMD, SCN_NOISE} traffic_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  rbl_in_t     in_data = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  rbl_out_t    out_data;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_index = CFG_OFF_PERIOD;
  logic [15:0] cfg_wdata = '0;

  // shadow copy of the controller and its registers
  rbl_cfg_t    shadow_cfg;
  logic [2:0]  shadow_mode;
  logic [2:0]  shadow_zero_run;
  logic        shadow_ctl0;
  logic        shadow_ctl1;
  logic        shadow_txd;
  logic        shadow_timer_on;
  logic [15:0] shadow_period;

  rbl_out_t expected_reports[$];
  int fail_count = 0;
  int cycle_count = 0;
  bit idle_on = 1'b0;
  int hold_left = 0;
  int stall_left = 0;

  radio_bit_low_power_listen dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Reload the compare period for a rate level; levels 0 and 3 also clear the counter
  function automatic void load_rate(input logic [1:0] level, inout rbl_out_t rep);
    case (level)
      RATE_ON: begin
        shadow_period = shadow_cfg.on_period;
        rep.clear_counter = 1'b1;
      end
      RATE_ONE: shadow_period = shadow_cfg.rate_one_period;
      RATE_TWO: shadow_period = shadow_cfg.rate_two_period;
      default: begin
        shadow_period = shadow_cfg.full_bit_period;
        rep.clear_counter = 1'b1;
      end
    endcase
    rep.load_compare = 1'b1;
  endfunction

  // Advance the shadow controller by one item and build the report it gives
  function automatic rbl_out_t predict_report(input rbl_in_t item);
    rbl_out_t rep;
    rep = '0;
    case (item.opcode)
      OP_TICK: begin
        // a stopped timer raises no interrupt, so the tick does nothing
        if (shadow_timer_on) begin
          case (shadow_mode)
            RM_TX: rep.tx_bit_request = 1'b1;
            RM_RX: begin
              if (item.rx_pin)
                shadow_zero_run = '0;
              else if (shadow_zero_run < ZERO_RUN_MAX)
                shadow_zero_run = shadow_zero_run + 3'd1;
              rep.rx_bit_valid = 1'b1;
              rep.rx_bit = item.rx_pin;
              if (shadow_zero_run > shadow_cfg.silence_limit) shadow_mode = RM_SENSE_OFF;
            end
            RM_SENSE_OFF: begin
              // off window over: radio on for a short look
              shadow_mode = RM_SENSE_ON;
              shadow_period = shadow_cfg.on_period;
              rep.load_compare = 1'b1;
              shadow_ctl0 = 1'b1;
              shadow_ctl1 = 1'b1;
            end
            RM_SENSE_ON: begin
              rep.rx_bit_valid = 1'b1;
              rep.rx_bit = item.rx_pin;
              if (item.rx_pin) begin
                load_rate(RATE_FULL, rep);
                shadow_mode = RM_RX;
                shadow_zero_run = '0;
              end else begin
                shadow_mode = RM_SENSE_OFF;
                shadow_period = shadow_cfg.off_period;
                rep.load_compare = 1'b1;
                shadow_ctl0 = 1'b0;
                shadow_ctl1 = 1'b0;
              end
            end
            default: ;
          endcase
        end
      end
      OP_SEND_BIT: begin
        if (shadow_mode == RM_TX) begin
          shadow_txd = item.argument[0];
          rep.ack = 1'b1;
        end
      end
      OP_POWER: begin
        if (item.argument == PWR_OFF) begin
          shadow_ctl0 = 1'b0;
          shadow_ctl1 = 1'b0;
          shadow_timer_on = 1'b0;
          shadow_mode = RM_OFF;
        end else if (item.argument == PWR_ON) begin
          shadow_mode = RM_SENSE_OFF;
          shadow_timer_on = 1'b1;
        end
        rep.ack = 1'b1;
      end
      OP_TX_MODE: begin
        shadow_ctl0 = 1'b1;
        shadow_ctl1 = 1'b0;
        shadow_mode = RM_TX;
        rep.ack = 1'b1;
      end
      OP_RX_MODE: begin
        shadow_ctl0 = 1'b1;
        shadow_ctl1 = 1'b1;
        shadow_txd = 1'b0;
        load_rate(RATE_FULL, rep);
        shadow_mode = RM_SENSE_ON;
        rep.ack = 1'b1;
      end
      OP_SET_RATE: begin
        load_rate(item.argument, rep);
        rep.ack = 1'b1;
      end
      default: ;
    endcase
    rep.ctl0 = shadow_ctl0;
    rep.ctl1 = shadow_ctl1;
    rep.txd = shadow_txd;
    rep.compare_value = shadow_period;
    rep.timer_enable = shadow_timer_on;
    rep.radio_mode = shadow_mode;
    return rep;
  endfunction

  function automatic rbl_in_t item_of(input logic [2:0] op, input logic pin,
                                      input logic [1:0] arg);
    rbl_in_t it;
    it.opcode = op;
    it.rx_pin = pin;
    it.argument = arg;
    return it;
  endfunction

  // One item of a traffic burst; step counts items within the burst
  function automatic rbl_in_t random_item(input traffic_t kind, input int step);
    rbl_in_t it;
    it.rx_pin = ($urandom_range(0, 7) == 0);
    it.argument = 2'($urandom_range(0, 3));
    case (kind)
      SCN_LISTEN: it.opcode = OP_TICK;
      SCN_TX: begin
        if (step == 0)
          it.opcode = OP_TX_MODE;
        else if (step % 2 == 1)
          it.opcode = OP_TICK;
        else
          it.opcode = OP_SEND_BIT;
      end
      SCN_CMD: begin
        case ($urandom_range(0, 6))
          0: it.opcode = OP_SET_RATE;
          1: it.opcode = OP_RX_MODE;
          2: it.opcode = OP_POWER;
          3: it.opcode = OP_TX_MODE;
          default: it.opcode = OP_TICK;
        endcase
      end
      default: begin
        it.opcode = 3'($urandom_range(0, 7));
        it.rx_pin = 1'($urandom_range(0, 1));
      end
    endcase
    return it;
  endfunction

  // Offer one item, with an optional idle burst first, and wait for its transfer
  task automatic send_item(input rbl_in_t item);
    int gap;
    gap = 0;
    if (idle_on && $urandom_range(0, 4) == 0) gap = $urandom_range(1, 7);
    @(negedge clk);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= item;
    do @(posedge clk); while (!in_ready);
  endtask

  // Drop valid and let every outstanding report come back
  task automatic wait_idle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_reports.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_register(input logic [2:0] index, input logic [15:0] value);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= index;
    cfg_wdata <= value;
    @(posedge clk);
    case (index)
      CFG_OFF_PERIOD:      shadow_cfg.off_period = value;
      CFG_ON_PERIOD:       shadow_cfg.on_period = value;
      CFG_FULL_BIT_PERIOD: shadow_cfg.full_bit_period = value;
      CFG_RATE_ONE_PERIOD: shadow_cfg.rate_one_period = value;
      CFG_RATE_TWO_PERIOD: shadow_cfg.rate_two_period = value;
      CFG_SILENCE_LIMIT:   shadow_cfg.silence_limit = value[2:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic load_settings(input logic [15:0] off_p, input logic [15:0] on_p,
                               input logic [15:0] full_p, input logic [15:0] one_p,
                               input logic [15:0] two_p, input logic [2:0] silence);
    wait_idle();
    write_register(CFG_OFF_PERIOD, off_p);
    write_register(CFG_ON_PERIOD, on_p);
    write_register(CFG_FULL_BIT_PERIOD, full_p);
    write_register(CFG_RATE_ONE_PERIOD, one_p);
    write_register(CFG_RATE_TWO_PERIOD, two_p);
    write_register(CFG_SILENCE_LIMIT, {13'd0, silence});
  endtask

  // Mix of listen runs, transmit sessions, commands and raw noise
  task automatic run_traffic(input int count);
    int sent;
    int len;
    int k;
    int pick;
    traffic_t kind;
    sent = 0;
    while (sent < count) begin
      pick = $urandom_range(0, 9);
      if (pick < 5)
        kind = SCN_LISTEN;
      else if (pick < 7)
        kind = SCN_TX;
      else if (pick < 9)
        kind = SCN_CMD;
      else
        kind = SCN_NOISE;
      len = $urandom_range(4, 30);
      for (k = 0; k < len && sent < count; k++) begin
        send_item(random_item(kind, k));
        sent++;
      end
    end
  endtask

  task automatic test_directed_cases();
    int k;
    send_item(item_of(OP_TICK, 1'b1, 2'd3));
    // zero run long enough to drop into the listen cycle
    for (k = 0; k < 7; k++) send_item(item_of(OP_TICK, 1'b0, 2'(k)));
    send_item(item_of(OP_TICK, 1'b0, 2'd0));
    send_item(item_of(OP_TICK, 1'b0, 2'd0));
    send_item(item_of(OP_TICK, 1'b1, 2'd0));
    send_item(item_of(OP_TICK, 1'b1, 2'd0));
    // send bit refused outside transmit
    send_item(item_of(OP_SEND_BIT, 1'b0, 2'd1));
    send_item(item_of(OP_TX_MODE, 1'b0, 2'd0));
    send_item(item_of(OP_TICK, 1'b1, 2'd0));
    send_item(item_of(OP_SEND_BIT, 1'b1, 2'd3));
    send_item(item_of(OP_SEND_BIT, 1'b0, 2'd2));
    send_item(item_of(OP_SET_RATE, 1'b0, RATE_ON));
    send_item(item_of(OP_SET_RATE, 1'b0, RATE_ONE));
    send_item(item_of(OP_SET_RATE, 1'b0, RATE_TWO));
    send_item(item_of(OP_SET_RATE, 1'b0, RATE_FULL));
    // power arguments 2 and 3 change nothing
    send_item(item_of(OP_POWER, 1'b0, 2'd2));
    send_item(item_of(OP_POWER, 1'b1, 2'd3));
    send_item(item_of(OP_POWER, 1'b0, PWR_OFF));
    send_item(item_of(OP_TICK, 1'b1, 2'd0));
    send_item(item_of(OP_POWER, 1'b0, PWR_ON));
    send_item(item_of(OP_RX_MODE, 1'b0, 2'd0));
    send_item(item_of(OP_SPARE_SIX, 1'b1, 2'd1));
    send_item(item_of(OP_SPARE_SEVEN, 1'b0, 2'd2));
  endtask

  task automatic test_register_settings();
    load_settings(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 3'd0);
    run_traffic(75);
    // silence limit 7: the zero run saturates and never starts a listen cycle
    load_settings(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 3'd7);
    run_traffic(75);
    load_settings(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                  16'($urandom), 3'($urandom_range(0, 7)));
    run_traffic(75);
    load_settings(RST_OFF_PERIOD, RST_ON_PERIOD, RST_FULL_BIT_PERIOD,
                  RST_RATE_ONE_PERIOD, RST_RATE_TWO_PERIOD, RST_SILENCE_LIMIT);
    run_traffic(75);
  endtask

  // Receiver stops for a long stretch while the sender keeps offering
  task automatic test_output_backpressure();
    idle_on = 1'b0;
    hold_left = 150;
    run_traffic(40);
    idle_on = 1'b1;
  endtask

  task automatic test_random_traffic();
    int blk;
    for (blk = 0; blk < 14; blk++) begin
      idle_on = ($urandom_range(0, 3) != 0);
      run_traffic(100);
    end
    // closing stretch at full rate
    idle_on = 1'b0;
    run_traffic(300);
  endtask

  // Receiver ready: long hold, random stall bursts, otherwise ready
  always @(negedge clk) begin
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      out_ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left = stall_left - 1;
      out_ready <= 1'b0;
    end else if (idle_on && $urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(0, 6);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Predict on input transfer, compare on result transfer
  always @(posedge clk) begin : scoreboard
    rbl_out_t want;
    string bad;
    if (rst_n) begin
      if (in_valid && in_ready) expected_reports.push_back(predict_report(in_data));
      if (out_valid && out_ready) begin
        if (expected_reports.size() == 0) begin
          fail_count++;
          if (fail_count <= SHOWN_MISMATCHES)
            $display("%0t: report %h with nothing outstanding", $realtime, out_data);
        end else begin
          want = expected_reports.pop_front();
          bad = "";
          if (out_data.ack !== want.ack) bad = {bad, " ack"};
          if (out_data.rx_bit_valid !== want.rx_bit_valid) bad = {bad, " rx_bit_valid"};
          if (out_data.rx_bit !== want.rx_bit) bad = {bad, " rx_bit"};
          if (out_data.tx_bit_request !== want.tx_bit_request) bad = {bad, " tx_bit_request"};
          if (out_data.ctl0 !== want.ctl0) bad = {bad, " ctl0"};
          if (out_data.ctl1 !== want.ctl1) bad = {bad, " ctl1"};
          if (out_data.txd !== want.txd) bad = {bad, " txd"};
          if (out_data.compare_value !== want.compare_value) bad = {bad, " compare_value"};
          if (out_data.load_compare !== want.load_compare) bad = {bad, " load_compare"};
          if (out_data.clear_counter !== want.clear_counter) bad = {bad, " clear_counter"};
          if (out_data.timer_enable !== want.timer_enable) bad = {bad, " timer_enable"};
          if (out_data.radio_mode !== want.radio_mode) bad = {bad, " radio_mode"};
          if (bad != "") begin
            fail_count++;
            if (fail_count <= SHOWN_MISMATCHES)
              $display("%0t: mismatch in%s: expected %h, got %h",
                       $realtime, bad, want, out_data);
          end
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("cycle limit hit, %0d reports outstanding", expected_reports.size());
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    shadow_cfg.off_period = RST_OFF_PERIOD;
    shadow_cfg.on_period = RST_ON_PERIOD;
    shadow_cfg.full_bit_period = RST_FULL_BIT_PERIOD;
    shadow_cfg.rate_one_period = RST_RATE_ONE_PERIOD;
    shadow_cfg.rate_two_period = RST_RATE_TWO_PERIOD;
    shadow_cfg.silence_limit = RST_SILENCE_LIMIT;
    shadow_mode = RM_RX;
    shadow_zero_run = '0;
    shadow_ctl0 = 1'b1;
    shadow_ctl1 = 1'b1;
    shadow_txd = 1'b0;
    shadow_timer_on = 1'b1;
    shadow_period = RST_FULL_BIT_PERIOD;
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;
    idle_on = 1'b1;

    test_directed_cases();
    test_register_settings();
    test_output_backpressure();
    test_random_traffic();

    wait_idle();
    fail_count += expected_reports.size();
    if (fail_count == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule
